// ===== hdl/lrp_pkg.sv =====
// Shared types and constants of the layer residency pager.
package lrp_pkg;

  localparam int StampW = 48;
  localparam int LayerW = 7;
  localparam int CountW = 8;
  localparam int BytesW = 40;
  localparam int OffsetW = 47;

  localparam logic [1:0] KIND_HIT = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd2;
  localparam logic [1:0] KIND_PREFETCH = 2'd3;

  localparam logic CFG_LAYER_COUNT = 1'b0;
  localparam logic CFG_LAYER_BYTES = 1'b1;

  // Oldest-so-far candidate travelling along the cell row.
  typedef struct packed {
    logic              found;
    logic [StampW-1:0] stamp;
    logic [9:0]        idx;
  } lrp_cand_t;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic              load;
    logic [9:0]        load_idx;
    logic [StampW-1:0] load_stamp;
    logic              evict;
    logic [9:0]        evict_idx;
  } lrp_cmd_t;

endpackage

// ===== hdl/layer_residency_pager.sv =====
// Layer residency pager: least-recently-loaded replacement with sequential prefetch.
// Sequence: the access result is shown from S_OUT after the S_ACC and S_MUL states; each prefetch
// then runs a scan along the cell row in S_SCAN, then S_MUL and S_OUT, waiting in S_OUT for ready.
// Throughput: one access at a time; a new beat is taken only once all its results are out.
// Reset: nothing resident, stamps zero, layer_count 80, layer_bytes 0; no clearing pass.
module layer_residency_pager
  import lrp_pkg::*;
#(
  parameter int MAX_LAYERS = 128,
  parameter int PREFETCH_AHEAD = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // layer[6:0], now_ms[54:7]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // which_layer, model_offset, evicted_valid, evicted_layer
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [39:0] cfg_data
);

  localparam int PaW = $clog2(PREFETCH_AHEAD + 1) + 1;
  localparam int ScanW = $clog2(MAX_LAYERS + 4);
  localparam int IdxW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_ACC = 6'b000010, S_AOUT = 6'b000100,
    S_SCAN = 6'b001000, S_MUL = 6'b010000, S_OUT = 6'b100000
  } state_t;

  state_t state;
  logic [CountW-1:0] layer_count;
  logic [BytesW-1:0] layer_bytes;
  logic [LayerW-1:0] lay;
  logic [StampW-1:0] now;
  logic [10:0] cnt;
  logic [PREFETCH_AHEAD-1:0] cand;
  logic [PaW-1:0] step;
  logic [ScanW-1:0] scan;
  logic [LayerW-1:0] pf_layer;
  logic [1:0] r_kind;
  logic [LayerW-1:0] r_layer;
  logic r_ev_valid, r_last;
  logic [LayerW-1:0] r_ev_layer;
  logic [OffsetW-1:0] r_off;
  lrp_cmd_t cmd;
  lrp_cand_t chain [MAX_LAYERS+1];
  logic [MAX_LAYERS-1:0] res;
  logic [MAX_LAYERS-1:0] scope;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign cnt = (11'(layer_count) > 11'(MAX_LAYERS)) ? 11'(MAX_LAYERS) : 11'(layer_count);
  assign chain[0] = '{found: 1'b0, stamp: '0, idx: '0};

  genvar g;
  generate
    for (g = 0; g < MAX_LAYERS; g++) begin : g_cell
      assign scope[g] = 11'(g) < cnt;
      lrp_cell #(.IDX(g)) u_cell (
        .clk(clk), .rst(rst), .cmd(cmd), .in_scope(scope[g]),
        .cand_in(chain[g]), .cand_out(chain[g+1]), .resident(res[g])
      );
    end
  endgenerate

  // Resident flag of a layer index, zero beyond the array.
  function automatic logic res_at(input logic [MAX_LAYERS-1:0] r, input logic [10:0] i);
    res_at = (i < 11'(MAX_LAYERS)) ? r[i[IdxW-1:0]] : 1'b0;
  endfunction

  logic [PREFETCH_AHEAD-1:0] cand_next;
  logic [LayerW-1:0] next_pf;
  logic have_next;
  always_comb begin
    cand_next = '0;
    for (int i = 1; i <= PREFETCH_AHEAD; i++) begin
      cand_next[i-1] = (11'(lay) + 11'(i) < cnt) && !res_at(res, 11'(lay) + 11'(i));
    end
    have_next = 1'b0;
    next_pf = '0;
    for (int i = PREFETCH_AHEAD; i >= 1; i--) begin
      if (cand[i-1] && PaW'(i) > step) begin
        have_next = 1'b1;
        next_pf = lay + LayerW'(i);
      end
    end
  end

  logic [PaW-1:0] next_step;
  always_comb begin
    next_step = step;
    for (int i = PREFETCH_AHEAD; i >= 1; i--) begin
      if (cand[i-1] && PaW'(i) > step) next_step = PaW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= CountW'(80);
      layer_bytes <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LAYER_COUNT: layer_count <= cfg_data[CountW-1:0];
        CFG_LAYER_BYTES: layer_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      cmd.load <= 1'b0;
      cmd.evict <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          cmd.load <= 1'b0;
          cmd.evict <= 1'b0;
          if (s_axis_tvalid) begin
            lay <= s_axis_tdata[6:0];
            now <= s_axis_tdata[54:7];
            state <= S_ACC;
          end
        end
        S_ACC: begin
          r_layer <= lay;
          r_ev_valid <= 1'b0;
          r_ev_layer <= '0;
          step <= '0;
          cmd.evict <= 1'b0;
          cmd.load <= (11'(lay) < cnt) && !res_at(res, 11'(lay));
          if (11'(lay) >= cnt) begin
            r_kind <= KIND_INVALID;
            r_last <= 1'b1;
          end else if (res_at(res, 11'(lay))) begin
            r_kind <= KIND_HIT;
          end else begin
            r_kind <= KIND_LOAD;
            cmd.load_idx <= 10'(lay);
            cmd.load_stamp <= now;
          end
          state <= S_MUL;
        end
        S_MUL: begin
          cmd.load <= 1'b0;
          cmd.evict <= 1'b0;
          r_off <= OffsetW'(r_layer) * OffsetW'(layer_bytes);
          if (r_kind != KIND_PREFETCH && r_kind != KIND_INVALID) begin
            cand <= cand_next;
            r_last <= (cand_next == '0);
          end
          m_axis_tvalid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          cmd.load <= 1'b0;
          cmd.evict <= 1'b0;
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (r_last) begin
              state <= S_IDLE;
            end else begin
              pf_layer <= next_pf;
              step <= next_step;
              scan <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          scan <= scan + 1'b1;
          if (scan == ScanW'(MAX_LAYERS + 1)) begin
            r_kind <= KIND_PREFETCH;
            r_layer <= pf_layer;
            r_ev_valid <= chain[MAX_LAYERS].found;
            r_ev_layer <= chain[MAX_LAYERS].found ? chain[MAX_LAYERS].idx[LayerW-1:0] : '0;
            cmd.evict <= chain[MAX_LAYERS].found;
            cmd.evict_idx <= chain[MAX_LAYERS].idx;
            cmd.load <= 1'b1;
            cmd.load_idx <= 10'(pf_layer);
            cmd.load_stamp <= now;
            r_last <= !have_next;
            state <= S_MUL;
          end else begin
            cmd.load <= 1'b0;
            cmd.evict <= 1'b0;
          end
        end
        default: begin
          cmd.load <= 1'b0;
          cmd.evict <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {2'b0, r_ev_layer, r_ev_valid, r_off, r_layer};
  assign m_axis_tuser = r_kind;
  assign m_axis_tlast = r_last;

  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> state == S_OUT) else $error("result shown outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid) else $error("input ready while result pending");

endmodule

// ===== hdl/lrp_cell.sv =====
// One residency cell: holds a layer's flag and stamp and keeps the oldest candidate.
module lrp_cell
  import lrp_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  lrp_cmd_t  cmd,
  input  logic      in_scope,
  input  lrp_cand_t cand_in,
  output lrp_cand_t cand_out,
  output logic      resident
);

  logic [StampW-1:0] stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      resident <= 1'b0;
    end else if (cmd.load && cmd.load_idx == 10'(IDX)) begin
      resident <= 1'b1;
    end else if (cmd.evict && cmd.evict_idx == 10'(IDX)) begin
      resident <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp <= '0;
    end else if (cmd.load && cmd.load_idx == 10'(IDX)) begin
      stamp <= cmd.load_stamp;
    end
  end

  // Strict compare keeps the lower index on equal stamps.
  always_ff @(posedge clk) begin
    if (resident && in_scope && (!cand_in.found || stamp < cand_in.stamp)) begin
      cand_out.found <= 1'b1;
      cand_out.stamp <= stamp;
      cand_out.idx   <= 10'(IDX);
    end else begin
      cand_out <= cand_in;
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the layer residency pager: directed table, then random accesses.
module tb_top;
  import lrp_pkg::*;

  localparam int NumLayers = 128;
  localparam int Ahead = 3;
  localparam int CycleLimit = 400000;
  localparam logic [OffsetW-1:0] OffMask = {OffsetW{1'b1}};

  typedef struct packed {
    logic [1:0]         kind;
    logic [LayerW-1:0]  layer;
    logic [OffsetW-1:0] offset;
    logic               ev_valid;
    logic [LayerW-1:0]  ev_layer;
    logic               last;
  } page_result_t;

  typedef struct {
    logic [LayerW-1:0] layer;
    logic [15:0]       dt;
    logic              known;
    logic [1:0]        kind;
  } access_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;   // layer[6:0], now_ms[54:7]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // which_layer, model_offset, evicted_valid, evicted_layer
  logic [1:0]  m_axis_tuser;   // kind
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [39:0] cfg_data;

  layer_residency_pager #(.MAX_LAYERS(NumLayers), .PREFETCH_AHEAD(Ahead)) dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Shadow copy of the residency state.
  logic               resident [NumLayers];
  logic [StampW-1:0]  stamp [NumLayers];
  logic [CountW-1:0]  count_reg;
  logic [BytesW-1:0]  bytes_reg;
  page_result_t       pending_pages [$];

  int                 errors = 0;
  int                 cycles = 0;
  logic               hold_req;
  int                 hold_left;
  logic [StampW-1:0]  now_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic page_result_t make_page(input logic [1:0] kind, input logic [LayerW-1:0] lay,
                                             input logic ev_v, input logic [LayerW-1:0] ev_l);
    page_result_t r;
    r.kind = kind;
    r.layer = lay;
    r.offset = OffsetW'(64'(lay) * 64'(bytes_reg)) & OffMask;
    r.ev_valid = ev_v;
    r.ev_layer = ev_l;
    r.last = 1'b0;
    return r;
  endfunction

  // Works out every result beat of one access and updates the shadow state.
  task automatic predict_pages(input logic [LayerW-1:0] lay, input logic [StampW-1:0] now);
    int cnt;
    int cand [$];
    int best;
    logic found;
    page_result_t r;
    cnt = (count_reg > NumLayers) ? NumLayers : int'(count_reg);
    if (int'(lay) >= cnt) begin
      r = make_page(KIND_INVALID, lay, 1'b0, '0);
      r.last = 1'b1;
      pending_pages = {pending_pages, r};
    end else begin
      if (resident[lay]) begin
        r = make_page(KIND_HIT, lay, 1'b0, '0);
      end else begin
        resident[lay] = 1'b1;
        stamp[lay] = now;
        r = make_page(KIND_LOAD, lay, 1'b0, '0);
      end
      pending_pages = {pending_pages, r};
      for (int i = 1; i <= Ahead; i++) begin
        if (int'(lay) + i >= cnt) break;
        if (!resident[int'(lay) + i]) cand = {cand, int'(lay) + i};
      end
      foreach (cand[c]) begin
        found = 1'b0;
        best = 0;
        for (int j = 0; j < cnt; j++) begin
          if (resident[j] && (!found || stamp[j] < stamp[best])) begin
            best = j;
            found = 1'b1;
          end
        end
        if (found) resident[best] = 1'b0;
        resident[cand[c]] = 1'b1;
        stamp[cand[c]] = now;
        r = make_page(KIND_PREFETCH, LayerW'(cand[c]), found, found ? LayerW'(best) : '0);
        pending_pages = {pending_pages, r};
      end
      pending_pages[$].last = 1'b1;
    end
  endtask

  task automatic send_access(input logic [LayerW-1:0] lay, input logic [StampW-1:0] now);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, now, lay};
    do @(posedge clk); while (!s_axis_tready);
    predict_pages(lay, now);
  endtask

  task automatic sender_gap();
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_pages.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [39:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_LAYER_COUNT) count_reg = value[CountW-1:0];
    else bytes_reg = value;
  endtask

  // Receiver: random stalls, plus long hold-offs while a hold is requested.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req && hold_left == 0) begin
      hold_left <= 1500;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 39) == 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
      hold_left <= 0;
    end
  end

  always @(posedge clk) begin
    page_result_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_pages.size() == 0) begin
        report("unexpected beat", m_axis_tdata, '0);
      end else begin
        w = pending_pages.pop_front();
        if (m_axis_tuser !== w.kind) report("kind", 64'(m_axis_tuser), 64'(w.kind));
        if (m_axis_tdata[6:0] !== w.layer)
          report("which_layer", 64'(m_axis_tdata[6:0]), 64'(w.layer));
        if (m_axis_tdata[53:7] !== w.offset)
          report("model_offset", 64'(m_axis_tdata[53:7]), 64'(w.offset));
        if (m_axis_tdata[54] !== w.ev_valid)
          report("evicted_valid", 64'(m_axis_tdata[54]), 64'(w.ev_valid));
        if (m_axis_tdata[61:55] !== w.ev_layer)
          report("evicted_layer", 64'(m_axis_tdata[61:55]), 64'(w.ev_layer));
        if (m_axis_tlast !== w.last) report("last", 64'(m_axis_tlast), 64'(w.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  access_row_t rows [15] = '{
    '{7'd0,   16'd0, 1'b1, KIND_LOAD},
    '{7'd127, 16'd0, 1'b1, KIND_INVALID},
    '{7'd80,  16'd1, 1'b1, KIND_INVALID},
    '{7'd79,  16'd1, 1'b1, KIND_LOAD},
    '{7'd77,  16'd1, 1'b0, KIND_HIT},
    '{7'd78,  16'd0, 1'b0, KIND_HIT},
    '{7'd2,   16'd5, 1'b0, KIND_HIT},
    '{7'd3,   16'd0, 1'b0, KIND_HIT},
    '{7'd1,   16'd2, 1'b0, KIND_HIT},
    '{7'd0,   16'd0, 1'b0, KIND_HIT},
    '{7'd0,   16'd0, 1'b0, KIND_HIT},
    '{7'd40,  16'd9, 1'b0, KIND_HIT},
    '{7'd41,  16'd0, 1'b0, KIND_HIT},
    '{7'd39,  16'd1, 1'b0, KIND_HIT},
    '{7'd76,  16'd3, 1'b0, KIND_HIT}
  };

  initial begin
    int cnt;
    logic [LayerW-1:0] lay;
    logic [CountW-1:0] counts [5] = '{8'd128, 8'd255, 8'd5, 8'd0, 8'd40};
    hold_req = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LAYER_COUNT;
    cfg_data = '0;
    count_reg = 8'd80;
    bytes_reg = '0;
    now_t = '0;
    for (int i = 0; i < NumLayers; i++) begin
      resident[i] = 1'b0;
      stamp[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[r]) begin
      now_t = now_t + StampW'(rows[r].dt);
      send_access(rows[r].layer, now_t);
      if (rows[r].known && pending_pages[0].kind !== rows[r].kind)
        report("table kind", 64'(pending_pages[0].kind), 64'(rows[r].kind));
      sender_gap();
    end
    drain();

    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_LAYER_COUNT, 40'(counts[p]));
      case (p)
        0: write_reg(CFG_LAYER_BYTES, {BytesW{1'b1}});
        3: write_reg(CFG_LAYER_BYTES, 40'd1);
        default: write_reg(CFG_LAYER_BYTES, 40'({$urandom, $urandom}));
      endcase
      // The last phase runs close to the top of the time range.
      if (p == 4) now_t = 48'hFFFF_FFF0_0000;
      if (p == 1) hold_req <= 1'b1;
      cnt = (counts[p] > NumLayers) ? NumLayers : int'(counts[p]);
      for (int n = 0; n < 24; n++) begin
        if (n == 2) hold_req <= 1'b0;
        if (cnt > 0 && $urandom_range(0, 4) != 0) lay = LayerW'($urandom_range(0, cnt - 1));
        else lay = LayerW'($urandom);
        if (p < 4 && $urandom_range(0, 15) == 0) now_t = now_t + StampW'($urandom);
        else now_t = now_t + StampW'($urandom_range(0, 3));
        send_access(lay, now_t);
        if (p != 1 || n > 8) sender_gap();
      end
      drain();
    end

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== layer_residency_pager.f =====
hdl/lrp_pkg.sv
hdl/lrp_cell.sv
hdl/layer_residency_pager.sv
test/tb_top.sv
